// ----- rtl/nsr_pkg.sv -----
package nsr_pkg;

  localparam int unsigned NUM_TYPES = 6;
  localparam int unsigned SLOT_W = 3;
  localparam int unsigned NUM_SLOTS = NUM_TYPES + 1;
  localparam logic [2:0] TYPE_NONE = 3'd6;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam int unsigned TEMP_DEPTH_DEF = 256;
  localparam int unsigned STORE_LIMIT_DEF = 100;
  localparam int unsigned STORE_DEPTH_DEF = 128;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_CNT_W = 3;
  // entries that may be claimed before the stage register drains
  localparam logic [Q_CNT_W-1:0] Q_CREDIT = 3'd3;

  typedef enum logic [1:0] {
    KIND_RX      = 2'd0,
    KIND_READ    = 2'd1,
    KIND_LOCK    = 2'd2,
    KIND_RELEASE = 2'd3
  } nsr_kind_e;

  typedef struct packed {
    logic [7:0] read_byte;
    logic [6:0] read_length;
    logic       sentence_done;
    logic [2:0] done_type;
    logic       sentence_ready;
    logic [5:0] got_flags;
    logic       all_got;
    logic       overflow;
  } nsr_rsp_t;

  typedef struct packed {
    logic [Q_CNT_W-1:0] count;
  } nsr_qstat_t;

  localparam logic [23:0] TYPE_NAMES [NUM_TYPES] = '{
    {8'h47, 8'h47, 8'h41},  // GGA
    {8'h47, 8'h4C, 8'h4C},  // GLL
    {8'h47, 8'h53, 8'h41},  // GSA
    {8'h47, 8'h53, 8'h56},  // GSV
    {8'h52, 8'h4D, 8'h43},  // RMC
    {8'h56, 8'h54, 8'h47}   // VTG
  };

  // map the three type letters to a type code, TYPE_NONE if unknown
  function automatic logic [2:0] match_type(input logic [23:0] letters);
    logic [2:0] res;
    res = TYPE_NONE;
    for (int t = NUM_TYPES - 1; t >= 0; t--) begin
      if (letters == TYPE_NAMES[t]) res = 3'(t);
    end
    return res;
  endfunction

endpackage

// ----- rtl/nsr_in_if.sv -----
interface nsr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] rx_byte;
  logic [2:0] read_type;
  logic [6:0] read_index;
  logic       lock_value;

  modport source (output valid, kind, rx_byte, read_type, read_index, lock_value,
                  input ready);
  modport sink (input valid, kind, rx_byte, read_type, read_index, lock_value,
                output ready);
endinterface

// ----- rtl/nsr_out_if.sv -----
interface nsr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic [6:0] read_length;
  logic       sentence_done;
  logic [2:0] done_type;
  logic       sentence_ready;
  logic [5:0] got_flags;
  logic       all_got;
  logic       overflow;

  modport source (output valid, read_byte, read_length, sentence_done, done_type,
                  sentence_ready, got_flags, all_got, overflow, input ready);
  modport sink (input valid, read_byte, read_length, sentence_done, done_type,
                sentence_ready, got_flags, all_got, overflow, output ready);
endinterface

// ----- rtl/nsr_front.sv -----
module nsr_front #(
  parameter int unsigned TEMP_DEPTH  = 256,
  parameter int unsigned STORE_LIMIT = 100,
  parameter int unsigned STORE_DEPTH = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  nsr_in_if.sink              req,
  input  nsr_pkg::nsr_qstat_t qstat_i,
  output logic                push_o,
  output nsr_pkg::nsr_rsp_t   rsp_o
);
  import nsr_pkg::*;

  localparam int unsigned CW = $clog2(TEMP_DEPTH + 1);
  localparam int unsigned LW = (CW > 8) ? CW : 8;
  localparam int unsigned IW = $clog2(STORE_DEPTH);
  localparam int unsigned AW = $clog2(NUM_SLOTS * STORE_DEPTH);
  localparam int unsigned CAP_A = (STORE_LIMIT < STORE_DEPTH) ? STORE_LIMIT : STORE_DEPTH;
  localparam int unsigned CAP = (CAP_A < 127) ? CAP_A : 127;

  logic              in_q, in_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [23:0]       let_q, let_d;
  logic [6:0]        len_q [NUM_TYPES];
  logic [6:0]        len_d [NUM_TYPES];
  logic [SLOT_W-1:0] map_q [NUM_TYPES];
  logic [SLOT_W-1:0] map_d [NUM_TYPES];
  logic [SLOT_W-1:0] cur_q, cur_d;
  logic [5:0]        got_q, got_d;
  logic              lock_q, lock_d;
  logic              rdy_q, rdy_d;
  logic              ovf_q, ovf_d;

  logic              acc;
  nsr_kind_e         kind;
  logic [2:0]        typ;
  logic [LW-1:0]     cnt_x;
  logic              mem_we;
  logic [AW-1:0]     waddr, raddr;
  logic              hit;
  nsr_rsp_t          rsp_d;

  logic              s1_valid_q;
  nsr_rsp_t          s1_rsp_q;
  logic              s1_hit_q;
  logic [7:0]        rd_q;
  logic [7:0]        mem [NUM_SLOTS * STORE_DEPTH];

  assign kind = nsr_kind_e'(req.kind);
  assign acc = req.valid && req.ready;
  // admit a beat only while the queue can absorb it and the one in flight
  assign req.ready = ({1'b0, qstat_i.count} + {3'b000, s1_valid_q}) < {1'b0, Q_CREDIT};

  // next state and result of the accepted beat
  always_comb begin
    in_d = in_q;
    cnt_d = cnt_q;
    let_d = let_q;
    len_d = len_q;
    map_d = map_q;
    cur_d = cur_q;
    got_d = got_q;
    lock_d = lock_q;
    rdy_d = rdy_q;
    ovf_d = ovf_q;
    typ = TYPE_NONE;
    cnt_x = '0;
    mem_we = 1'b0;
    waddr = '0;
    raddr = '0;
    hit = 1'b0;
    rsp_d = '0;
    if (acc) begin
      unique case (kind)
        KIND_RX: begin
          if (req.rx_byte == CH_DOLLAR) begin
            in_d = 1'b1;
            cnt_d = '0;
            rdy_d = 1'b0;
          end
          // close the sentence and rename the filled slot into its type
          if (req.rx_byte == CH_NEWLINE && in_d) begin
            if (cnt_d >= CW'(6)) typ = match_type(let_q);
            in_d = 1'b0;
            rdy_d = 1'b1;
            rsp_d.sentence_done = 1'b1;
            rsp_d.done_type = typ;
            if (typ != TYPE_NONE) begin
              if (!lock_q) begin
                cnt_x = LW'(cnt_d) - LW'(3);
                len_d[typ] = (cnt_x > LW'(CAP)) ? 7'(CAP) : 7'(cnt_x);
                map_d[typ] = cur_q;
                cur_d = map_q[typ];
              end
              got_d[typ] = 1'b1;
            end
          end
          // gather the character
          if (in_d) begin
            if (cnt_d < CW'(TEMP_DEPTH)) begin
              if (cnt_d == CW'(3)) let_d[23:16] = req.rx_byte;
              if (cnt_d == CW'(4)) let_d[15:8] = req.rx_byte;
              if (cnt_d == CW'(5)) let_d[7:0] = req.rx_byte;
              cnt_x = LW'(cnt_d) - LW'(3);
              if (cnt_d >= CW'(3) && cnt_x < LW'(CAP)) begin
                mem_we = 1'b1;
                waddr = AW'(cur_q) * AW'(STORE_DEPTH) + AW'(cnt_x[IW-1:0]);
              end
              cnt_d = cnt_d + CW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
        KIND_READ: begin
          if (req.read_type < 3'(NUM_TYPES)) begin
            rsp_d.read_length = len_q[req.read_type];
            hit = req.read_index < len_q[req.read_type];
            raddr = AW'(map_q[req.read_type]) * AW'(STORE_DEPTH)
                  + AW'(req.read_index[IW-1:0]);
          end
        end
        KIND_LOCK: begin
          lock_d = req.lock_value;
        end
        KIND_RELEASE: begin
          for (int k = 0; k < NUM_TYPES; k++) len_d[k] = '0;
          got_d = '0;
          lock_d = 1'b0;
        end
        default: ;
      endcase
    end
    rsp_d.sentence_ready = rdy_d;
    rsp_d.got_flags = got_d;
    rsp_d.all_got = &got_d;
    rsp_d.overflow = ovf_d;
  end

  // hold framing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q <= 1'b0;
      cnt_q <= '0;
      for (int k = 0; k < NUM_TYPES; k++) begin
        len_q[k] <= '0;
        map_q[k] <= SLOT_W'(k);
      end
      cur_q <= SLOT_W'(NUM_TYPES);
      got_q <= '0;
      lock_q <= 1'b0;
      rdy_q <= 1'b0;
      ovf_q <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      in_q <= in_d;
      cnt_q <= cnt_d;
      len_q <= len_d;
      map_q <= map_d;
      cur_q <= cur_d;
      got_q <= got_d;
      lock_q <= lock_d;
      rdy_q <= rdy_d;
      ovf_q <= ovf_d;
      s1_valid_q <= acc;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    let_q <= let_d;
    s1_rsp_q <= rsp_d;
    s1_hit_q <= hit;
  end

  // slot memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= req.rx_byte;
    if (acc && kind == KIND_READ) rd_q <= mem[raddr];
  end

  // merge read data and push
  always_comb begin
    rsp_o = s1_rsp_q;
    rsp_o.read_byte = s1_hit_q ? rd_q : 8'h00;
  end
  assign push_o = s1_valid_q;

  a_cur_unmapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q != map_q[0] && cur_q != map_q[1] && cur_q != map_q[2] &&
    cur_q != map_q[3] && cur_q != map_q[4] && cur_q != map_q[5])
    else $error("spare slot aliases a mapped slot");
  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> rsp_o.read_length <= 7'(CAP))
    else $error("read length beyond cap");
  a_done_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && rsp_o.sentence_done |-> rsp_o.sentence_ready)
    else $error("sentence end without ready flag");
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q)
    else $error("overflow flag cleared");

endmodule

// ----- rtl/nsr_queue.sv -----
module nsr_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  nsr_pkg::nsr_rsp_t   rsp_i,
  output nsr_pkg::nsr_qstat_t qstat_o,
  nsr_out_if.source           rsp
);
  import nsr_pkg::*;

  localparam int unsigned PW = $clog2(Q_DEPTH);

  nsr_rsp_t           buf_q [Q_DEPTH];
  logic [PW-1:0]      wr_q, rd_q;
  logic [Q_CNT_W-1:0] cnt_q;
  logic               pop;
  nsr_rsp_t           head;

  assign pop = rsp.valid && rsp.ready;
  assign qstat_o.count = cnt_q;
  assign head = buf_q[rd_q];

  // drive the head beat
  assign rsp.valid = cnt_q != '0;
  assign rsp.read_byte = head.read_byte;
  assign rsp.read_length = head.read_length;
  assign rsp.sentence_done = head.sentence_done;
  assign rsp.done_type = head.done_type;
  assign rsp.sentence_ready = head.sentence_ready;
  assign rsp.got_flags = head.got_flags;
  assign rsp.all_got = head.all_got;
  assign rsp.overflow = head.overflow;

  // advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + PW'(1);
      if (pop) rd_q <= rd_q + PW'(1);
      cnt_q <= cnt_q + Q_CNT_W'(push_i) - Q_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wr_q] <= rsp_i;
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && !pop && cnt_q == Q_CNT_W'(Q_DEPTH)))
    else $error("queue overrun");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < Q_CNT_W'(Q_DEPTH) |-> PW'(wr_q - rd_q) == cnt_q[PW-1:0])
    else $error("queue pointers disagree with count");

endmodule

// ----- rtl/nmea_sentence_receiver_core.sv -----
// NMEA sentence receiver.
// req_i carries one beat per request: a received character (kind 0), a read
// of a stored character (kind 1), a write lock change (kind 2) or a release
// of all stores and got flags (kind 3). rsp_o returns exactly one beat per
// request, in order, with the read data, end-of-sentence report and the
// status flags after that request.
// Throughput is one request per cycle while the output queue has room. A
// response passes through the stage register and registered read of the slot
// memory, then through the output queue, before the receiver can take it.
// Sentence text is written straight into a spare slot of the memory as it
// arrives; at the newline a recognized sentence, unless the stores are locked,
// swaps that slot with the slot of its type, so no copy is needed.
// Reset clears framing state, lengths, flags and the lock; the memory is
// not cleared and needs no sweep. When the receiver stalls rsp_o, up to
// three beats collect in the queue and then req_i.ready drops until the
// receiver takes a beat.
module nmea_sentence_receiver_core #(
  parameter int unsigned TEMP_DEPTH  = nsr_pkg::TEMP_DEPTH_DEF,
  parameter int unsigned STORE_LIMIT = nsr_pkg::STORE_LIMIT_DEF,
  parameter int unsigned STORE_DEPTH = nsr_pkg::STORE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  nsr_in_if.sink    req_i,
  nsr_out_if.source rsp_o
);
  import nsr_pkg::*;

  nsr_qstat_t qstat;
  nsr_rsp_t   push_rsp;
  logic       push;

  nsr_front #(
    .TEMP_DEPTH (TEMP_DEPTH),
    .STORE_LIMIT(STORE_LIMIT),
    .STORE_DEPTH(STORE_DEPTH)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_i),
    .qstat_i(qstat),
    .push_o (push),
    .rsp_o  (push_rsp)
  );

  nsr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rsp_i  (push_rsp),
    .qstat_o(qstat),
    .rsp    (rsp_o)
  );

endmodule

// ----- verif/tb_nmea_sentence_receiver_core.sv -----
`timescale 1ns / 100ps

module tb_nmea_sentence_receiver_core;
  import nsr_pkg::*;

  localparam int unsigned CAP = (STORE_LIMIT_DEF < STORE_DEPTH_DEF) ?
                                ((STORE_LIMIT_DEF < 127) ? STORE_LIMIT_DEF : 127) :
                                ((STORE_DEPTH_DEF < 127) ? STORE_DEPTH_DEF : 127);

  typedef struct {
    nsr_kind_e  kind;
    logic [7:0] rx;
    logic [2:0] rtype;
    logic [6:0] ridx;
    logic       lockv;
  } req_beat_t;

  logic clk_i;
  logic rst_ni;

  nsr_in_if  req_if ();
  nsr_out_if rsp_if ();

  nmea_sentence_receiver_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  // framer image tracked beside the block
  logic       fr_in_sentence;
  int         fr_count;
  logic [7:0] fr_text [TEMP_DEPTH_DEF];
  logic [7:0] fr_store [NUM_TYPES][STORE_DEPTH_DEF];
  int         fr_len [NUM_TYPES];
  logic [5:0] fr_got;
  logic       fr_lock;
  logic       fr_ready;
  logic       fr_ovf;

  req_beat_t  pending_q [$];
  nsr_rsp_t   expected_q [$];
  int         n_queued;
  int         n_accepted;
  int         n_mismatch;
  int         n_sentences;
  int         n_recognized;
  int         n_reads;
  int         n_overflow_beats;
  logic       no_idle;
  logic       long_hold_req;

  // apply one request to the image and return the response it causes
  function automatic nsr_rsp_t predict_response(req_beat_t b);
    nsr_rsp_t   r;
    logic [2:0] t;
    int         len;
    r = '0;
    case (b.kind)
      KIND_RX: begin
        if (b.rx == CH_DOLLAR) begin
          fr_in_sentence = 1'b1;
          fr_count = 0;
          fr_ready = 1'b0;
        end
        if (b.rx == CH_NEWLINE && fr_in_sentence) begin
          t = TYPE_NONE;
          if (fr_count >= 6) begin
            for (int k = NUM_TYPES - 1; k >= 0; k--) begin
              if ({fr_text[3], fr_text[4], fr_text[5]} == TYPE_NAMES[k]) t = 3'(k);
            end
          end
          fr_in_sentence = 1'b0;
          if (t != TYPE_NONE) begin
            if (!fr_lock) begin
              len = fr_count - 3;
              if (len > CAP) len = CAP;
              for (int i = 0; i < len; i++) fr_store[t][i] = fr_text[3 + i];
              fr_len[t] = len;
            end
            fr_got[t] = 1'b1;
            n_recognized++;
          end
          fr_ready = 1'b1;
          r.sentence_done = 1'b1;
          r.done_type = t;
          n_sentences++;
        end
        if (fr_in_sentence) begin
          if (fr_count < TEMP_DEPTH_DEF) begin
            fr_text[fr_count] = b.rx;
            fr_count++;
          end else begin
            fr_ovf = 1'b1;
          end
        end
      end
      KIND_READ: begin
        n_reads++;
        if (b.rtype < NUM_TYPES) begin
          r.read_length = 7'(fr_len[b.rtype]);
          if (b.ridx < fr_len[b.rtype]) r.read_byte = fr_store[b.rtype][b.ridx];
        end
      end
      KIND_LOCK: fr_lock = b.lockv;
      default: begin
        for (int i = 0; i < NUM_TYPES; i++) fr_len[i] = 0;
        fr_got = '0;
        fr_lock = 1'b0;
      end
    endcase
    r.sentence_ready = fr_ready;
    r.got_flags = fr_got;
    r.all_got = &fr_got;
    r.overflow = fr_ovf;
    if (fr_ovf) n_overflow_beats++;
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // driver: offer queued requests with random gaps
  int src_wait;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid      <= 1'b0;
      req_if.kind       <= KIND_RX;
      req_if.rx_byte    <= '0;
      req_if.read_type  <= '0;
      req_if.read_index <= '0;
      req_if.lock_value <= 1'b0;
      src_wait = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        req_beat_t b;
        b.kind  = nsr_kind_e'(req_if.kind);
        b.rx    = req_if.rx_byte;
        b.rtype = req_if.read_type;
        b.ridx  = req_if.read_index;
        b.lockv = req_if.lock_value;
        expected_q.push_back(predict_response(b));
        n_accepted++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (src_wait > 0) begin
          src_wait--;
          req_if.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          req_beat_t b;
          b = pending_q.pop_front();
          req_if.kind       <= b.kind;
          req_if.rx_byte    <= b.rx;
          req_if.read_type  <= b.rtype;
          req_if.read_index <= b.ridx;
          req_if.lock_value <= b.lockv;
          req_if.valid      <= 1'b1;
          src_wait = no_idle ? 0 : $urandom_range(0, 11);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // count down a long receiver hold
  int long_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_left <= 0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      long_left <= 300;
    end else if (long_left > 0) begin
      long_left <= long_left - 1;
    end
  end

  // monitor: take response beats, compare with the oldest expectation
  int snk_wait;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      snk_wait = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        nsr_rsp_t a;
        nsr_rsp_t e;
        a.read_byte      = rsp_if.read_byte;
        a.read_length    = rsp_if.read_length;
        a.sentence_done  = rsp_if.sentence_done;
        a.done_type      = rsp_if.done_type;
        a.sentence_ready = rsp_if.sentence_ready;
        a.got_flags      = rsp_if.got_flags;
        a.all_got        = rsp_if.all_got;
        a.overflow       = rsp_if.overflow;
        if (expected_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("%0t: response beat with none expected: %p", $realtime, a);
        end else begin
          e = expected_q.pop_front();
          if (a.read_byte !== e.read_byte || a.read_length !== e.read_length ||
              a.sentence_done !== e.sentence_done || a.done_type !== e.done_type ||
              a.sentence_ready !== e.sentence_ready || a.got_flags !== e.got_flags ||
              a.all_got !== e.all_got || a.overflow !== e.overflow) begin
            n_mismatch++;
            if (n_mismatch <= 10) $display("%0t: mismatch\n  expected %p\n  actual   %p",
                                           $realtime, e, a);
          end
        end
        snk_wait = no_idle ? 0 : $urandom_range(0, 11);
      end
      if (long_left > 0) begin
        rsp_if.ready <= 1'b0;
      end else if (snk_wait > 0) begin
        snk_wait--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  task automatic push_req(nsr_kind_e k, logic [7:0] rx, logic [2:0] rt, logic [6:0] ri,
                          logic lv);
    req_beat_t b;
    b.kind = k;
    b.rx = rx;
    b.rtype = rt;
    b.ridx = ri;
    b.lockv = lv;
    pending_q.push_back(b);
    n_queued++;
  endtask

  task automatic push_byte(logic [7:0] c);
    push_req(KIND_RX, c, 3'($urandom_range(0, 7)), 7'($urandom), 1'($urandom));
  endtask

  // body character: mostly printable text, sometimes any byte but framing ones
  function automatic logic [7:0] body_char();
    logic [7:0] c;
    if ($urandom_range(0, 9) == 0) c = 8'($urandom);
    else c = 8'($urandom_range(8'h2C, 8'h5A));
    if (c == CH_DOLLAR || c == CH_NEWLINE) c = 8'h2C;
    return c;
  endfunction

  // one sentence; letters picks the type code, end_it adds the newline
  task automatic push_sentence(logic [23:0] letters, int body_len, logic end_it);
    push_byte(CH_DOLLAR);
    push_byte(8'h47);
    push_byte(8'h50);
    push_byte(letters[23:16]);
    push_byte(letters[15:8]);
    push_byte(letters[7:0]);
    for (int i = 0; i < body_len; i++) push_byte(body_char());
    if (end_it) push_byte(CH_NEWLINE);
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic push_random(int target);
    int r;
    int len;
    while (n_queued < target) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        len = $urandom_range(0, 30);
        if ($urandom_range(0, 19) == 0) len = $urandom_range(95, 120);
        if ($urandom_range(0, 149) == 0) len = $urandom_range(250, 262);
        push_sentence(TYPE_NAMES[$urandom_range(0, NUM_TYPES - 1)], len, 1'b1);
      end else if (r < 62) begin
        // broken: unknown type, truncated, or restarted before the newline
        case ($urandom_range(0, 2))
          0: push_sentence(24'($urandom), $urandom_range(0, 10), 1'b1);
          1: begin
            push_byte(CH_DOLLAR);
            for (int i = $urandom_range(0, 4); i > 0; i--) push_byte(body_char());
            push_byte(CH_NEWLINE);
          end
          default: push_sentence(TYPE_NAMES[$urandom_range(0, 5)], $urandom_range(0, 8), 1'b0);
        endcase
      end else if (r < 70) begin
        push_byte(8'($urandom));
      end else if (r < 88) begin
        push_req(KIND_READ, 8'($urandom), 3'($urandom_range(0, 7)),
                 $urandom_range(0, 1) ? 7'($urandom) : 7'($urandom_range(0, 40)), 1'($urandom));
      end else if (r < 95) begin
        push_req(KIND_LOCK, 8'($urandom), 3'($urandom), 7'($urandom),
                 $urandom_range(0, 3) == 0);
      end else begin
        push_req(KIND_RELEASE, 8'($urandom), 3'($urandom), 7'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    fr_in_sentence = 1'b0;
    fr_count = 0;
    for (int i = 0; i < NUM_TYPES; i++) fr_len[i] = 0;
    fr_got = '0;
    fr_lock = 1'b0;
    fr_ready = 1'b0;
    fr_ovf = 1'b0;
    n_queued = 0;
    n_accepted = 0;
    n_mismatch = 0;
    n_sentences = 0;
    n_recognized = 0;
    n_reads = 0;
    n_overflow_beats = 0;
    no_idle = 1'b0;
    long_hold_req = 1'b0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty reads, stray bytes, a short GGA, lock, release
    push_req(KIND_READ, 8'h00, 3'd0, 7'd0, 1'b0);
    push_byte(CH_NEWLINE);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_sentence(TYPE_NAMES[0], 2, 1'b1);
    push_req(KIND_READ, 8'h00, 3'd0, 7'd0, 1'b0);
    push_req(KIND_READ, 8'h00, 3'd0, 7'd4, 1'b0);
    push_req(KIND_READ, 8'h00, 3'd0, 7'd127, 1'b0);
    push_req(KIND_READ, 8'h00, 3'd7, 7'd0, 1'b0);
    push_req(KIND_LOCK, 8'h00, 3'd0, 7'd0, 1'b1);
    push_req(KIND_LOCK, 8'h00, 3'd0, 7'd0, 1'b0);
    push_req(KIND_RELEASE, 8'h00, 3'd0, 7'd0, 1'b0);
    push_req(KIND_READ, 8'h00, 3'd0, 7'd0, 1'b0);
    wait_drained();

    // receiver holds off while the sender keeps offering
    long_hold_req = 1'b1;
    push_random(400);
    wait_drained();

    // back-to-back stretch, then the rest with gaps and a long receiver hold
    no_idle = 1'b1;
    push_random(800);
    wait_drained();
    no_idle = 1'b0;
    long_hold_req = 1'b1;
    push_random(1550);
    wait_drained();
    repeat (20) @(posedge clk_i);

    if (expected_q.size() != 0) n_mismatch++;
    $display("Covered %0d requests: %0d sentence ends (%0d recognized), %0d reads,",
             n_accepted, n_sentences, n_recognized, n_reads);
    $display("  final got flags %b, %0d responses with overflow set, %0d mismatches",
             fr_got, n_overflow_beats, n_mismatch);
    if (n_mismatch == 0) begin
      $display("tb_nmea_sentence_receiver_core: PASS");
    end else begin
      $display("tb_nmea_sentence_receiver_core: FAIL");
    end
    $finish;
  end

  // stop a hung run
  initial begin
    #5ms;
    $display("Timeout with %0d requests accepted of %0d", n_accepted, n_queued);
    $display("tb_nmea_sentence_receiver_core: FAIL");
    $finish;
  end

endmodule

// ----- nmea_sentence_receiver_core.f -----
rtl/nsr_pkg.sv
rtl/nsr_in_if.sv
rtl/nsr_out_if.sv
rtl/nsr_front.sv
rtl/nsr_queue.sv
rtl/nmea_sentence_receiver_core.sv
verif/tb_nmea_sentence_receiver_core.sv
